// ===== rtl/vaar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_pkg: shared types, constants and functions
// Fixed-point constants, pipeline depths and result types used by the
// axis-angle rotation pipeline.
// ----------------------------------------------------------------------------
package vaar_pkg;

  // Number of CORDIC micro-rotations, from 12 to 32.
  localparam int CORDIC_STAGES = 24;

  localparam int NORM_STAGES = 5;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;

  // Abs and max, normalise, square, sum, root, numerator, divide, sign.
  localparam int AXIS_LAT   = 1 + NORM_STAGES + 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int ANG_DELAY  = AXIS_LAT - CORDIC_LAT;

  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [71:0] HALF_Q30    = 72'sd536870912;

  typedef struct packed {
    logic             zero;
    logic [2:0][31:0] k;
  } axis_res_t;

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [2:0][31:0] rot;
  } rot_res_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd843314857;
      5'd1:    a = 32'd497837829;
      5'd2:    a = 32'd263043837;
      5'd3:    a = 32'd133525159;
      5'd4:    a = 32'd67021687;
      5'd5:    a = 32'd33543516;
      5'd6:    a = 32'd16775851;
      5'd7:    a = 32'd8388437;
      5'd8:    a = 32'd4194283;
      5'd9:    a = 32'd2097149;
      5'd10:   a = 32'd1048576;
      5'd11:   a = 32'd524288;
      5'd12:   a = 32'd262144;
      5'd13:   a = 32'd131072;
      5'd14:   a = 32'd65536;
      5'd15:   a = 32'd32768;
      5'd16:   a = 32'd16384;
      5'd17:   a = 32'd8192;
      5'd18:   a = 32'd4096;
      5'd19:   a = 32'd2048;
      5'd20:   a = 32'd1024;
      5'd21:   a = 32'd512;
      5'd22:   a = 32'd256;
      5'd23:   a = 32'd128;
      5'd24:   a = 32'd64;
      5'd25:   a = 32'd32;
      5'd26:   a = 32'd16;
      5'd27:   a = 32'd8;
      5'd28:   a = 32'd4;
      5'd29:   a = 32'd2;
      5'd30:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Q2.30 product reduction: floor((p + 2^29) / 2^30).
  function automatic logic signed [71:0] round30(input logic signed [71:0] p);
    return (p + HALF_Q30) >>> 30;
  endfunction

endpackage

// ===== rtl/vaar_axis_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_axis_norm: axis to unit vector
// Normalises the axis magnitudes, takes the length by a pipelined square
// root and divides each component by it with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module vaar_axis_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [31:0]         axis_x,
  input  logic signed [31:0]         axis_y,
  input  logic signed [31:0]         axis_z,
  output logic                       out_valid,
  output vaar_pkg::axis_res_t        out_res
);

  localparam int NS = vaar_pkg::NORM_STAGES;
  localparam int SQ = vaar_pkg::SQRT_STAGES;
  localparam int DS = vaar_pkg::DIV_STAGES;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } side_t;

  // Abs, max and zero test
  logic [2:0][31:0] n_in;
  side_t            side_in;
  logic [31:0]      m_in;

  always_comb begin
    n_in = {axis_z, axis_y, axis_x};
    side_in.zero = (n_in == '0);
    for (int l = 0; l < 3; l++) begin
      side_in.neg[l] = n_in[l][31];
      side_in.mag[l] = n_in[l][31] ? (~n_in[l] + 32'd1) : n_in[l];
    end
    m_in = side_in.mag[0];
    if (side_in.mag[1] > m_in) begin
      m_in = side_in.mag[1];
    end
    if (side_in.mag[2] > m_in) begin
      m_in = side_in.mag[2];
    end
  end

  logic        nv_r    [0:NS];
  side_t       nside_r [0:NS];
  logic [31:0] nm_r    [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r[0] <= 1'b0;
    end else if (en) begin
      nv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nside_r[0] <= side_in;
      nm_r[0]    <= m_in;
    end
  end

  // Binary search for the shift that lifts the largest magnitude to at least 2^30.
  for (genvar j = 1; j <= NS; j++) begin : g_norm
    localparam int K = 1 << (NS - j);
    logic sh;
    assign sh = ((nm_r[j-1] >> (31 - K)) == 32'd0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[j] <= 1'b0;
      end else if (en) begin
        nv_r[j] <= nv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nside_r[j].zero <= nside_r[j-1].zero;
        nside_r[j].neg  <= nside_r[j-1].neg;
        for (int l = 0; l < 3; l++) begin
          nside_r[j].mag[l] <= sh ? (nside_r[j-1].mag[l] << K) : nside_r[j-1].mag[l];
        end
        nm_r[j] <= sh ? (nm_r[j-1] << K) : nm_r[j-1];
      end
    end
  end

  // Squares
  logic             sqv_r;
  side_t            sqside_r;
  logic [2:0][63:0] sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r <= 1'b0;
    end else if (en) begin
      sqv_r <= nv_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqside_r <= nside_r[NS];
      for (int l = 0; l < 3; l++) begin
        sq_r[l] <= {32'd0, nside_r[NS].mag[l]} * {32'd0, nside_r[NS].mag[l]};
      end
    end
  end

  // Square root, one result bit per stage; index 0 holds the sum.
  logic        qv_r    [0:SQ];
  side_t       qside_r [0:SQ];
  logic [63:0] qs_r    [0:SQ];
  logic [63:0] qres_r  [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else if (en) begin
      qv_r[0] <= sqv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qside_r[0] <= sqside_r;
      qs_r[0]    <= sq_r[0] + sq_r[1] + sq_r[2];
      qres_r[0]  <= 64'd0;
    end
  end

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        ge;
    assign trial = qres_r[i] + BIT;
    assign ge    = (qs_r[i] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[i+1] <= 1'b0;
      end else if (en) begin
        qv_r[i+1] <= qv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qside_r[i+1] <= qside_r[i];
        qs_r[i+1]    <= ge ? (qs_r[i] - trial) : qs_r[i];
        qres_r[i+1]  <= ge ? ((qres_r[i] >> 1) + BIT) : (qres_r[i] >> 1);
      end
    end
  end

  // Numerator mag * 2^30 + len / 2, split into a partial remainder and the
  // bits still to be brought down. Index 0 of the divider.
  logic [31:0]      len;
  logic [2:0][61:0] num;

  always_comb begin
    len = qres_r[SQ][31:0];
    for (int l = 0; l < 3; l++) begin
      num[l] = {qside_r[SQ].mag[l], 30'd0} + {31'd0, len[31:1]};
    end
  end

  logic             dv_r    [0:DS];
  logic             dzero_r [0:DS];
  logic [2:0]       dneg_r  [0:DS];
  logic [31:0]      dlen_r  [0:DS];
  logic [2:0][31:0] drem_r  [0:DS];
  logic [2:0][30:0] dlq_r   [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= qv_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dzero_r[0] <= qside_r[SQ].zero;
      dneg_r[0]  <= qside_r[SQ].neg;
      dlen_r[0]  <= len;
      for (int l = 0; l < 3; l++) begin
        drem_r[0][l] <= {1'b0, num[l][61:31]};
        dlq_r[0][l]  <= num[l][30:0];
      end
    end
  end

  // Restoring division: the quotient bits shift in where numerator bits leave.
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [2:0][32:0] t;
    logic [2:0]       ge;
    logic [2:0][31:0] rem_n;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]     = {drem_r[j][l], dlq_r[j][l][30]};
        ge[l]    = (t[l] >= {1'b0, dlen_r[j]});
        rem_n[l] = ge[l] ? 32'(t[l] - {1'b0, dlen_r[j]}) : t[l][31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dzero_r[j+1] <= dzero_r[j];
        dneg_r[j+1]  <= dneg_r[j];
        dlen_r[j+1]  <= dlen_r[j];
        for (int l = 0; l < 3; l++) begin
          drem_r[j+1][l] <= rem_n[l];
          dlq_r[j+1][l]  <= {dlq_r[j][l][29:0], ge[l]};
        end
      end
    end
  end

  // Sign restore
  logic                fin_v_r;
  vaar_pkg::axis_res_t fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r.zero <= dzero_r[DS];
      for (int l = 0; l < 3; l++) begin
        fin_r.k[l] <= dneg_r[DS][l] ? (32'd0 - {1'b0, dlq_r[DS][l]}) : {1'b0, dlq_r[DS][l]};
      end
    end
  end

  assign out_valid = fin_v_r;
  assign out_res   = fin_r;

endmodule

// ===== rtl/vaar_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_cordic: pipelined sine and cosine
// Folds the angle into minus pi/2 to pi/2 and runs one CORDIC rotation per
// register stage, starting from the converged gain.
// ----------------------------------------------------------------------------
module vaar_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [30:0] angle,
  output logic signed [32:0] cos_q,
  output logic signed [32:0] sin_q
);

  localparam int CS = vaar_pkg::CORDIC_STAGES;

  logic signed [33:0] z4;
  logic signed [33:0] z_in;
  logic               flip_in;

  always_comb begin
    z4      = 34'(angle) <<< 2;
    z_in    = z4;
    flip_in = 1'b0;
    if (z4 > vaar_pkg::HALF_PI_Q30) begin
      z_in    = z4 - vaar_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (z4 < -vaar_pkg::HALF_PI_Q30) begin
      z_in    = z4 + vaar_pkg::PI_Q30;
      flip_in = 1'b1;
    end
  end

  logic signed [32:0] cx_r [0:CS];
  logic signed [32:0] cy_r [0:CS];
  logic signed [33:0] cz_r [0:CS];
  logic               cf_r [0:CS];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= vaar_pkg::GAIN_Q30;
      cy_r[0] <= 33'sd0;
      cz_r[0] <= z_in;
      cf_r[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_rot
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [33:0] at;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign at = $signed({2'b00, vaar_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[i+1] <= cf_r[i];
        if (!cz_r[i][33]) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - at;
        end else begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + at;
        end
      end
    end
  end

  logic signed [32:0] cos_r;
  logic signed [32:0] sin_r;

  // A folded angle turns both results round by pi.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cf_r[CS] ? -cx_r[CS] : cx_r[CS];
      sin_r <= cf_r[CS] ? -cy_r[CS] : cy_r[CS];
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

// ===== rtl/vaar_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_rotate: Rodrigues product
// Forms k.v and k x v, then v*cos + (k x v)*sin + k*(k.v)*(1 - cos) with
// at most one multiplier level per stage, and saturates the result.
// ----------------------------------------------------------------------------
module vaar_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  vaar_pkg::axis_res_t in_res,
  input  logic [2:0][31:0]    vec,
  input  logic signed [32:0]  cos_q,
  input  logic signed [32:0]  sin_q,
  output logic                out_valid,
  output vaar_pkg::rot_res_t  out_res
);

  logic valid_r [0:5];
  logic zero_r  [0:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= in_res.zero;
      for (int i = 1; i < 6; i++) begin
        zero_r[i] <= zero_r[i-1];
      end
    end
  end

  // Stage 0: dot and cross products
  logic signed [31:0] ks [0:2];
  logic signed [31:0] vs [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ks[l] = $signed(in_res.k[l]);
      vs[l] = $signed(vec[l]);
    end
  end

  logic signed [31:0] k0_r  [0:2];
  logic signed [31:0] v0_r  [0:2];
  logic signed [32:0] c0_r;
  logic signed [32:0] s0_r;
  logic signed [63:0] pd0_r [0:2];
  logic signed [63:0] px0_r [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        k0_r[l]  <= ks[l];
        v0_r[l]  <= vs[l];
        pd0_r[l] <= ks[l] * vs[l];
      end
      px0_r[0] <= ks[1] * vs[2];
      px0_r[1] <= ks[2] * vs[1];
      px0_r[2] <= ks[2] * vs[0];
      px0_r[3] <= ks[0] * vs[2];
      px0_r[4] <= ks[0] * vs[1];
      px0_r[5] <= ks[1] * vs[0];
      c0_r <= cos_q;
      s0_r <= sin_q;
    end
  end

  // Stage 1: reduce k.v and k x v
  logic signed [71:0] d_full;
  logic signed [71:0] w_full [0:2];

  always_comb begin
    d_full = vaar_pkg::round30(72'(pd0_r[0] + pd0_r[1] + pd0_r[2]));
    for (int l = 0; l < 3; l++) begin
      w_full[l] = vaar_pkg::round30(72'(px0_r[2*l] - px0_r[2*l+1]));
    end
  end

  logic signed [31:0] k1_r [0:2];
  logic signed [31:0] v1_r [0:2];
  logic signed [32:0] c1_r;
  logic signed [32:0] s1_r;
  logic signed [33:0] d1_r;
  logic signed [33:0] w1_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        k1_r[l] <= k0_r[l];
        v1_r[l] <= v0_r[l];
        w1_r[l] <= w_full[l][33:0];
      end
      d1_r <= d_full[33:0];
      c1_r <= c0_r;
      s1_r <= s0_r;
    end
  end

  // Stage 2: k*(k.v), v*cos and (k x v)*sin
  logic signed [65:0] pe2_r  [0:2];
  logic signed [64:0] pvc2_r [0:2];
  logic signed [66:0] pws2_r [0:2];
  logic signed [33:0] omc2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pe2_r[l]  <= k1_r[l] * d1_r;
        pvc2_r[l] <= v1_r[l] * c1_r;
        pws2_r[l] <= w1_r[l] * s1_r;
      end
      omc2_r <= vaar_pkg::ONE_Q30 - 34'(c1_r);
    end
  end

  // Stage 3: reduce the products
  logic signed [71:0] e_full  [0:2];
  logic signed [71:0] t1_full [0:2];
  logic signed [71:0] t2_full [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      e_full[l]  = vaar_pkg::round30(72'(pe2_r[l]));
      t1_full[l] = vaar_pkg::round30(72'(pvc2_r[l]));
      t2_full[l] = vaar_pkg::round30(72'(pws2_r[l]));
    end
  end

  logic signed [33:0] e3_r   [0:2];
  logic signed [35:0] t13_r  [0:2];
  logic signed [35:0] t23_r  [0:2];
  logic signed [33:0] omc3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        e3_r[l]  <= e_full[l][33:0];
        t13_r[l] <= t1_full[l][35:0];
        t23_r[l] <= t2_full[l][35:0];
      end
      omc3_r <= omc2_r;
    end
  end

  // Stage 4: e*(1 - cos)
  logic signed [67:0] pm4_r [0:2];
  logic signed [35:0] t14_r [0:2];
  logic signed [35:0] t24_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pm4_r[l] <= e3_r[l] * omc3_r;
        t14_r[l] <= t13_r[l];
        t24_r[l] <= t23_r[l];
      end
    end
  end

  // Stage 5: exact sum of the three terms
  logic signed [71:0] t3_full [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t3_full[l] = vaar_pkg::round30(72'(pm4_r[l]));
    end
  end

  logic signed [37:0] r5_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        r5_r[l] <= 38'(t14_r[l]) + 38'(t24_r[l]) + t3_full[l][37:0];
      end
    end
  end

  // Stage 6: saturate; a zero axis forces a zero result.
  vaar_pkg::rot_res_t res_nxt;
  logic               fin_v_r;
  vaar_pkg::rot_res_t fin_r;

  always_comb begin
    res_nxt.zero = zero_r[5];
    res_nxt.sat  = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (r5_r[l] > 38'sd2147483647) begin
        res_nxt.rot[l] = 32'h7fff_ffff;
        res_nxt.sat    = 1'b1;
      end else if (r5_r[l] < -38'sd2147483648) begin
        res_nxt.rot[l] = 32'h8000_0000;
        res_nxt.sat    = 1'b1;
      end else begin
        res_nxt.rot[l] = r5_r[l][31:0];
      end
    end
    if (zero_r[5]) begin
      res_nxt.rot = '0;
      res_nxt.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= valid_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= res_nxt;
    end
  end

  assign out_valid = fin_v_r;
  assign out_res   = fin_r;

endmodule

// ===== rtl/vector_axis_angle_rotation.sv =====
`timescale 1ns / 1ps
// Path: axis path, rotation stages, then the output register that drives out_valid.
// Throughput: one item per cycle while in_stall is low; the pipeline advances as one
// unit and a two-entry output register (result plus skid) absorbs one item on a stall.
// The depth is set by the axis path (square root and divider, one bit a stage).
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// vector_axis_angle_rotation: axis-angle rotation of a 3D vector
// Unit axis, CORDIC sine and cosine and the Rodrigues product, all pipelined,
// with delay lines keeping the vector and angle in step with the axis.
// ----------------------------------------------------------------------------
module vector_axis_angle_rotation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [30:0] in_angle,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic               out_zero_axis,
  output logic               out_saturated
);

  localparam int AL = vaar_pkg::AXIS_LAT;
  localparam int AD = vaar_pkg::ANG_DELAY;

  logic en;
  logic skid_v_r;

  // The whole pipeline moves whenever the skid register is free.
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Vector and angle delay lines
  logic [2:0][31:0]   vd_r [0:AL-1];
  logic signed [30:0] ad_r [0:AD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= {in_vec_z, in_vec_y, in_vec_x};
      for (int i = 1; i < AL; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      ad_r[0] <= in_angle;
      for (int i = 1; i < AD; i++) begin
        ad_r[i] <= ad_r[i-1];
      end
    end
  end

  logic                ax_v;
  vaar_pkg::axis_res_t ax_res;
  logic signed [32:0]  cos_q;
  logic signed [32:0]  sin_q;
  logic                rv;
  vaar_pkg::rot_res_t  rres;

  vaar_axis_norm u_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .axis_x    (in_axis_x),
    .axis_y    (in_axis_y),
    .axis_z    (in_axis_z),
    .out_valid (ax_v),
    .out_res   (ax_res)
  );

  vaar_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .angle (ad_r[AD-1]),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  vaar_rotate u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ax_v),
    .in_res    (ax_res),
    .vec       (vd_r[AL-1]),
    .cos_q     (cos_q),
    .sin_q     (sin_q),
    .out_valid (rv),
    .out_res   (rres)
  );

  // Output register and skid register
  logic               out_v_r;
  logic               out_v_nxt;
  vaar_pkg::rot_res_t out_res_r;
  vaar_pkg::rot_res_t out_res_nxt;
  logic               skid_v_nxt;
  vaar_pkg::rot_res_t skid_res_r;
  vaar_pkg::rot_res_t skid_res_nxt;
  logic               take;

  always_comb begin
    take         = out_v_r && !out_stall;
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    skid_v_nxt   = skid_v_r;
    skid_res_nxt = skid_res_r;
    if (skid_v_r) begin
      if (take) begin
        out_res_nxt = skid_res_r;
        skid_v_nxt  = 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_nxt   = rv;
      out_res_nxt = rres;
    end else if (rv) begin
      skid_v_nxt   = 1'b1;
      skid_res_nxt = rres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_rot_x     = $signed(out_res_r.rot[0]);
  assign out_rot_y     = $signed(out_res_r.rot[1]);
  assign out_rot_z     = $signed(out_res_r.rot[2]);
  assign out_zero_axis = out_res_r.zero;
  assign out_saturated = out_res_r.sat;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> !skid_v_r)
    else $error("skid register not emptied after the output item was taken");

  a_zero_axis_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |->
      out_rot_x == 32'sd0 && out_rot_y == 32'sd0 && out_rot_z == 32'sd0 && !out_saturated)
    else $error("zero axis item with a non-zero result");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_rot_x == 32'sh7fffffff || out_rot_x == 32'sh80000000 ||
      out_rot_y == 32'sh7fffffff || out_rot_y == 32'sh80000000 ||
      out_rot_z == 32'sh7fffffff || out_rot_z == 32'sh80000000)
    else $error("saturation flagged with no component at a bound");

endmodule

// ===== dv/tb_vector_axis_angle_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_axis_angle_rotation: self-checking testbench
// Drives directed and random vectors, angles and axes through the rotation
// pipeline with random gaps and stalls, and compares every result with a
// listed expected result or an in-bench Rodrigues predictor.
// ----------------------------------------------------------------------------
module tb_vector_axis_angle_rotation;

  localparam int N_RANDOM = 1130;
  localparam int WD_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [30:0] ang;
    logic signed [31:0] ax, ay, az;
  } rot_item_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               zero, sat;
  } rot_out_t;

  typedef struct {
    rot_item_t item;
    bit        known;
    rot_out_t  res;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [30:0] in_angle;
  logic signed [31:0] in_axis_x, in_axis_y, in_axis_z;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z;
  logic out_zero_axis, out_saturated;

  rot_out_t   expected_rots[$];
  stim_row_t  stim_rows[$];
  int         errors = 0, n_in = 0, n_out = 0, n_sat = 0, n_zero = 0, idle_cycles = 0;
  bit         stim_done = 0;

  vector_axis_angle_rotation i_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd30(longint p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                      128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic rot_out_t rodrigues(rot_item_t it);
    rot_out_t o;
    longint v[3], n[3], k[3], w[3], x, y, z, c, s, d, omc, e, r, dx, dy;
    longint unsigned mag[3], m, sq, len, q;
    int sh;
    bit flip;
    v = '{it.vx, it.vy, it.vz};
    n = '{it.ax, it.ay, it.az};
    o = '{0, 0, 0, 0, 0};
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      o.zero = 1;
      return o;
    end
    m = 0; sq = 0; sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      if (mag[i] > m) m = mag[i];
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      sh++;
    end
    for (int i = 0; i < 3; i++) begin
      mag[i] <<= sh;
      sq += mag[i] * mag[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * (64'd1 << 30) + len / 2) / len;
      k[i] = n[i] < 0 ? -longint'(q) : longint'(q);
    end
    // Fold the angle into minus half pi to half pi, negating sine and cosine.
    x = 652032874; y = 0; z = longint'(it.ang) * 4; flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < vaar_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = fl_shift(y, i);
      dy = fl_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = 64'sd1073741824 - c;
    d = rnd30(k[0] * v[0] + k[1] * v[1] + k[2] * v[2]);
    w[0] = rnd30(k[1] * v[2] - k[2] * v[1]);
    w[1] = rnd30(k[2] * v[0] - k[0] * v[2]);
    w[2] = rnd30(k[0] * v[1] - k[1] * v[0]);
    for (int i = 0; i < 3; i++) begin
      e = rnd30(k[i] * d);
      r = rnd30(v[i] * c) + rnd30(w[i] * s) + rnd30(e * omc);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647; o.sat = 1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648; o.sat = 1;
      end
      if (i == 0) o.rx = r[31:0];
      else if (i == 1) o.ry = r[31:0];
      else o.rz = r[31:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", n_out, what, got, want);
    errors++;
  endtask

  function automatic rot_item_t mk(longint vx, longint vy, longint vz, longint ang,
                                   longint ax, longint ay, longint az);
    rot_item_t it;
    it.vx = 32'(vx); it.vy = 32'(vy); it.vz = 32'(vz); it.ang = 31'(ang);
    it.ax = 32'(ax); it.ay = 32'(ay); it.az = 32'(az);
    return it;
  endfunction

  function automatic logic signed [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rot_item_t rnd_item();
    rot_item_t it;
    it.vx = rnd_comp(); it.vy = rnd_comp(); it.vz = rnd_comp();
    it.ang = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                       : 31'($signed($urandom_range(0, 1686629714)) - 843314857);
    it.ax = rnd_comp(); it.ay = rnd_comp(); it.az = rnd_comp();
    if ($urandom_range(0, 40) == 0) begin
      it.ax = 0; it.ay = 0; it.az = 0;
    end
    return it;
  endfunction

  // Called at a falling edge; valid stays high into the next item when there is no gap.
  task automatic drive_item(stim_row_t row);
    int gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1;
    in_vec_x  <= row.item.vx; in_vec_y <= row.item.vy; in_vec_z <= row.item.vz;
    in_angle  <= row.item.ang;
    in_axis_x <= row.item.ax; in_axis_y <= row.item.ay; in_axis_z <= row.item.az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rots.push_back(row.known ? row.res : rodrigues(row.item));
    n_in++;
    @(negedge clk);
  endtask

  initial begin
    stim_row_t row;
    rot_out_t zero_res;
    rst_n = 0; in_valid = 0; out_stall = 0;
    in_vec_x = 0; in_vec_y = 0; in_vec_z = 0; in_angle = 0;
    in_axis_x = 0; in_axis_y = 0; in_axis_z = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    zero_res = '{0, 0, 0, 1, 0};
    // Zero axis, with the outputs read straight off.
    stim_rows.push_back('{mk(32'h7fffffff, -32'sh80000000, 12345, 843314857, 0, 0, 0), 1,
                          zero_res});
    stim_rows.push_back('{mk(-1, -1, -1, -843314857, 0, 0, 0), 1, zero_res});
    // Zero angle and zero vector.
    stim_rows.push_back('{mk(65536, 131072, -65536, 0, 0, 0, 65536), 1,
                          '{65536, 131072, -65536, 0, 0}});
    stim_rows.push_back('{mk(0, 0, 0, 500000000, 1, 2, 3), 1, '{0, 0, 0, 0, 0}});
    // Angle extremes and quadrant folding, full 31-bit range.
    begin
      longint angs[8] = '{843314857, -843314857, 421657428, -421657428,
                          1073741823, -1073741824, 421657429, 1};
      foreach (angs[i])
        stim_rows.push_back('{mk(65536, 0, 0, angs[i], 0, 0, 65536), 0, zero_res});
    end
    // Axis extremes, tiny axes and saturation.
    stim_rows.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 421657428,
                             1, 0, 0), 0, zero_res});
    stim_rows.push_back('{mk(-32'sh80000000, -32'sh80000000, 32'h7fffffff, 300000000,
                             -32'sh80000000, -32'sh80000000, -32'sh80000000), 0, zero_res});
    stim_rows.push_back('{mk(32'h7fffffff, -32'sh80000000, 0, -600000000,
                             32'h7fffffff, 32'h7fffffff, 1), 0, zero_res});
    stim_rows.push_back('{mk(1000, -2000, 3000, 843314857, -1, -1, -1), 0, zero_res});
    stim_rows.push_back('{mk(-1, 1, -1, 100, 0, -1, 0), 0, zero_res});
    foreach (stim_rows[i]) drive_item(stim_rows[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      row.item = rnd_item();
      row.known = 0;
      drive_item(row);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver stalls: per item a random hold, sometimes none.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rot_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rots.size() == 0) begin
        report_mismatch("result count", n_out + 1, n_in);
      end else begin
        e = expected_rots.pop_front();
        if (out_rot_x !== e.rx) report_mismatch("rot_x", out_rot_x, e.rx);
        if (out_rot_y !== e.ry) report_mismatch("rot_y", out_rot_y, e.ry);
        if (out_rot_z !== e.rz) report_mismatch("rot_z", out_rot_z, e.rz);
        if (out_zero_axis !== e.zero) report_mismatch("zero_axis", out_zero_axis, e.zero);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        n_sat += e.sat;
        n_zero += e.zero;
      end
      n_out++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    fork
      begin
        wait (stim_done && expected_rots.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d items sent, %0d results checked (%0d saturated, %0d zero axis)",
                 n_in, n_out, n_sat, n_zero);
        if (errors == 0) begin
          $display("vector_axis_angle_rotation regression: pass");
        end else begin
          $display("vector_axis_angle_rotation regression: fail");
        end
      end
      begin
        wait (idle_cycles >= WD_LIMIT);
        $display("watchdog expired with %0d results outstanding", expected_rots.size());
        $display("vector_axis_angle_rotation regression: fail");
      end
    join_any
    $finish;
  end

endmodule
